// ----- hw/rtl/csvtok_pkg.sv -----
// csvtok_pkg: shared types and codes of the csv field/row tokenizer
// no dependencies; imported by every module of the block
package csvtok_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_INDEX_W-1:0] REG_SEPARATOR    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DELIMITER    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_QUOTE        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 3'd4;

    // error codes
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_UNTERMINATED = 3'd1;
    localparam logic [2:0] ERR_CORRUPT     = 3'd2;
    localparam logic [2:0] ERR_TOO_FEW     = 3'd3;
    localparam logic [2:0] ERR_TOO_MANY    = 3'd4;

    // input item
    typedef struct packed {
        logic [7:0] text_byte;
        logic       chunk_last;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [7:0]  field_byte;
        logic        is_content;
        logic        field_end;
        logic        row_end;
        logic [7:0]  column_index;
        logic [15:0] row_index;
        logic [2:0]  error_code;
    } out_item_t;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0] text_byte;
        logic       chunk_last;
        logic       is_escape;
        logic       is_separator;
        logic       is_delimiter;
        logic       is_quote;
    } class_t;

endpackage

// ----- hw/rtl/csvtok_front.sv -----
// csvtok_front: configuration registers and byte classification
// depends on csvtok_pkg
module csvtok_front
    import csvtok_pkg::*;
#(
    parameter int MAX_COLUMNS = 256,
    parameter int CNT_W       = 9
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  in_item_t               in_item,
    output class_t                 class_item,
    output logic [CNT_W-1:0]       col_limit
);

    logic [7:0] separator_reg;
    logic [7:0] delimiter_reg;
    logic [7:0] quote_reg;
    logic [7:0] escape_reg;
    logic [8:0] column_count_reg;

    // register writes, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            separator_reg    <= 8'd44;
            delimiter_reg    <= 8'd10;
            quote_reg        <= 8'd34;
            escape_reg       <= 8'd34;
            column_count_reg <= 9'd1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SEPARATOR:    separator_reg    <= cfg_data[7:0];
                REG_DELIMITER:    delimiter_reg    <= cfg_data[7:0];
                REG_QUOTE:        quote_reg        <= cfg_data[7:0];
                REG_ESCAPE:       escape_reg       <= cfg_data[7:0];
                REG_COLUMN_COUNT: column_count_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // compare byte against the special characters
    always_comb begin
        class_item.text_byte    = in_item.text_byte;
        class_item.chunk_last   = in_item.chunk_last;
        class_item.is_escape    = (in_item.text_byte == escape_reg);
        class_item.is_separator = (in_item.text_byte == separator_reg);
        class_item.is_delimiter = (in_item.text_byte == delimiter_reg);
        class_item.is_quote     = (in_item.text_byte == quote_reg);
    end

    // column count clamped to the supported maximum
    always_comb begin
        if (CNT_W'(column_count_reg) > CNT_W'(MAX_COLUMNS)) begin
            col_limit = CNT_W'(MAX_COLUMNS);
        end else begin
            col_limit = CNT_W'(column_count_reg);
        end
    end

endmodule

// ----- hw/rtl/csvtok_queue.sv -----
// csvtok_queue: two-entry queue of classified bytes between front and back
// depends on csvtok_pkg
module csvtok_queue
    import csvtok_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  class_t push_item,
    output logic   full,
    input  logic   pop,
    output logic   head_valid,
    output class_t head_item
);

    class_t     ent_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = ent_reg[rd_ptr_reg];

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (!push && pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    // pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- hw/rtl/csvtok_back.sv -----
// csvtok_back: field mode machine, column/row counters and result register
// depends on csvtok_pkg
module csvtok_back
    import csvtok_pkg::*;
#(
    parameter int MAX_COLUMNS    = 256,
    parameter int ROW_INDEX_BITS = 16,
    parameter int CNT_W          = 9
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             head_valid,
    input  class_t           head_item,
    output logic             pop,
    input  logic [CNT_W-1:0] col_limit,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data
);

    localparam int COL_W = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_W = (ROW_INDEX_BITS < 16) ? ROW_INDEX_BITS : 16;

    typedef enum logic [3:0] {
        MODE_START      = 4'b0001,
        MODE_PLAIN      = 4'b0010,
        MODE_QUOTED     = 4'b0100,
        MODE_QUOTE_SEEN = 4'b1000
    } mode_t;

    mode_t            mode_reg,   mode_next;
    logic [COL_W-1:0] col_reg,    col_next;
    logic [ROW_W-1:0] row_reg,    row_next;
    logic             hold_reg,   hold_next;
    logic             out_valid_reg;
    out_item_t        out_data_reg, out_data_next;

    mode_t            step_mode;
    logic             content;
    logic             term;
    logic             rowend;
    logic [2:0]       err;
    logic [CNT_W-1:0] newcol;
    logic [COL_W+7:0] col_ext;
    logic [ROW_W+15:0] row_ext;

    assign pop     = head_valid && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;
    assign col_ext = {8'd0, col_reg};
    assign row_ext = {16'd0, row_reg};

    // per-byte mode step
    always_comb begin
        step_mode = mode_reg;
        content   = 1'b0;
        term      = 1'b0;
        rowend    = 1'b0;
        err       = ERR_NONE;
        case (mode_reg)
            MODE_START: begin
                if (head_item.is_escape) begin
                    content   = 1'b1;
                    step_mode = MODE_QUOTED;
                end else if (head_item.is_separator || head_item.is_delimiter) begin
                    term   = 1'b1;
                    rowend = head_item.is_delimiter;
                end else begin
                    content   = 1'b1;
                    step_mode = MODE_PLAIN;
                end
            end
            MODE_PLAIN: begin
                if (head_item.is_separator || head_item.is_delimiter) begin
                    term   = 1'b1;
                    rowend = head_item.is_delimiter;
                end else begin
                    content = 1'b1;
                end
            end
            MODE_QUOTED: begin
                content = 1'b1;
                if (head_item.is_quote) begin
                    step_mode = MODE_QUOTE_SEEN;
                end
            end
            MODE_QUOTE_SEEN: begin
                if (head_item.is_quote) begin
                    content   = 1'b1;
                    step_mode = MODE_QUOTED;
                end else if (head_item.is_separator || head_item.is_delimiter) begin
                    term   = 1'b1;
                    rowend = head_item.is_delimiter;
                end else begin
                    err = ERR_CORRUPT;
                end
            end
            default: begin
                err = ERR_CORRUPT;
            end
        endcase

        // chunk end closes the field and the row, or flags an unterminated quoted field
        if (err == ERR_NONE && head_item.chunk_last) begin
            if (!term && step_mode == MODE_QUOTED) begin
                err = ERR_UNTERMINATED;
            end else begin
                term   = 1'b1;
                rowend = 1'b1;
            end
        end

        // column count check
        newcol = CNT_W'(col_reg) + CNT_W'(1);
        if (err == ERR_NONE && term) begin
            if (rowend) begin
                if (newcol != col_limit) begin
                    err = ERR_TOO_FEW;
                end else begin
                    newcol = '0;
                end
            end
            if (err == ERR_NONE && newcol >= col_limit) begin
                err = ERR_TOO_MANY;
            end
        end
    end

    // next state and result
    always_comb begin
        mode_next = mode_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        hold_next = hold_reg;

        out_data_next              = '0;
        out_data_next.column_index = col_ext[7:0];
        out_data_next.row_index    = row_ext[15:0];

        if (hold_reg) begin
            // discarding until chunk end
        end else if (err != ERR_NONE) begin
            out_data_next.error_code = err;
            hold_next                = 1'b1;
        end else begin
            out_data_next.field_byte = content ? head_item.text_byte : 8'd0;
            out_data_next.is_content = content;
            out_data_next.field_end  = term;
            out_data_next.row_end    = rowend;
            if (term) begin
                mode_next = MODE_START;
                col_next  = newcol[COL_W-1:0];
                if (rowend && row_reg != {ROW_W{1'b1}}) begin
                    row_next = row_reg + ROW_W'(1);
                end
            end else begin
                mode_next = step_mode;
            end
        end

        // chunk restart
        if (head_item.chunk_last) begin
            mode_next = MODE_START;
            col_next  = '0;
            row_next  = '0;
            hold_next = 1'b0;
        end
    end

    // state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_START;
            col_reg       <= '0;
            row_reg       <= '0;
            hold_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                mode_reg      <= mode_next;
                col_reg       <= col_next;
                row_reg       <= row_next;
                hold_reg      <= hold_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ----- hw/rtl/csv_field_row_tokenizer.sv -----
// csv_field_row_tokenizer: top level of the csv field/row tokenizer
// depends on csvtok_pkg, csvtok_front, csvtok_queue, csvtok_back
//
// Takes one byte of CSV text per item and returns one result item per byte,
// marking field and row ends, column and row positions and format errors.
// Items are taken at one per cycle while the queue has room: the front
// compares each byte against the separator, delimiter, quote and escape
// registers in the cycle it is accepted and writes it into a two-entry
// queue; the back pops one entry per cycle unless the result is stalled,
// steps the field mode machine and the column and row counters, and loads
// the result register. Configuration writes are taken in any cycle but must
// only be issued while no item is in flight.
module csv_field_row_tokenizer
    import csvtok_pkg::*;
#(
    parameter int MAX_COLUMNS    = 256,
    parameter int ROW_INDEX_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int COL_W = $clog2(MAX_COLUMNS + 1);
    localparam int CNT_W = (COL_W > 9) ? COL_W : 9;

    class_t           class_item;
    class_t           head_item;
    logic [CNT_W-1:0] col_limit;
    logic             queue_full;
    logic             head_valid;
    logic             pop;
    logic             push;

    assign cfg_ready = 1'b1;
    assign s_ready   = !queue_full;
    assign push      = s_valid && !queue_full;

    csvtok_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .CNT_W       (CNT_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_item    (s_data),
        .class_item (class_item),
        .col_limit  (col_limit)
    );

    csvtok_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (class_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    csvtok_back #(
        .MAX_COLUMNS    (MAX_COLUMNS),
        .ROW_INDEX_BITS (ROW_INDEX_BITS),
        .CNT_W          (CNT_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .col_limit  (col_limit),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // a row end always closes the field too
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.row_end |-> m_data.field_end)
        else $error("row end without field end");

    // an error item carries no text and no boundary marks
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error_code != ERR_NONE |->
            !m_data.is_content && !m_data.field_end && !m_data.row_end)
        else $error("error item carries content or marks");

    // non-content results carry a zero byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.is_content |-> m_data.field_byte == 8'd0)
        else $error("field byte set on non-content item");

    // nothing comes out right after reset
    assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

endmodule
